### rtl/ber_pkg.sv
`default_nettype none
package ber_pkg;

  localparam int unsigned LVL_W = 7;
  localparam int unsigned CLS_W = 5;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned STACK_SLOTS = 127;
  localparam int unsigned PTR_W = 7;

  localparam logic [CLS_W-1:0] C_L   = 5'd0;
  localparam logic [CLS_W-1:0] C_R   = 5'd1;
  localparam logic [CLS_W-1:0] C_BN  = 5'd9;
  localparam logic [CLS_W-1:0] C_B   = 5'd10;
  localparam logic [CLS_W-1:0] C_LRE = 5'd14;
  localparam logic [CLS_W-1:0] C_LRO = 5'd15;
  localparam logic [CLS_W-1:0] C_RLE = 5'd16;
  localparam logic [CLS_W-1:0] C_RLO = 5'd17;
  localparam logic [CLS_W-1:0] C_PDF = 5'd18;
  localparam logic [CLS_W-1:0] C_LRI = 5'd19;
  localparam logic [CLS_W-1:0] C_RLI = 5'd20;
  localparam logic [CLS_W-1:0] C_FSI = 5'd21;
  localparam logic [CLS_W-1:0] C_PDI = 5'd22;

  localparam logic [1:0] OV_NONE = 2'd0;
  localparam logic [1:0] OV_LTR  = 2'd1;
  localparam logic [1:0] OV_RTL  = 2'd2;

  typedef struct packed {
    logic [CLS_W-1:0] char_class;
    logic             fsi_is_rtl;
    logic             para_start;
  } in_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [CLS_W-1:0] out_class;
    logic             removed;
  } out_word_t;

  // one stack entry; below holds the depth of the nearest isolate entry under it
  typedef struct packed {
    logic             iso;
    logic [PTR_W-1:0] below;
    logic [1:0]       ov;
    logic [LVL_W-1:0] lvl;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/ber_ram.sv
`default_nettype none
module ber_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/bidi_explicit_level_resolver_core.sv
`default_nettype none
// explicit level resolver: each word first updates state and issues
// a stack memory access, then takes back the read data and registers the result
// accept sets busy_r, which then loads out_valid_r and out_r; no new word while busy
// the registered stack read sets the pace; a new word is taken as the last result leaves
// synchronous active-low reset: paragraph level 0, one entry on the stack,
// counters zero, no result pending; stack memory contents are not cleared
module bidi_explicit_level_resolver_core #(
  parameter int unsigned MAX_LEVEL = 125
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ber_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ber_pkg::out_word_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_data
);
  import ber_pkg::*;

  // architectural state; entry 0 lives in base_r, entries 1.. in memory
  logic             para_lvl_r;
  logic             base_r;
  entry_t           top_r, top_nxt;
  logic [PTR_W-1:0] depth_r, depth_nxt;
  logic [PTR_W-1:0] iso_dep_r, iso_dep_nxt;   // depth whose top is nearest isolate
  logic [CNT_W-1:0] ovfi_r, ovfi_nxt;
  logic [CNT_W-1:0] ovfe_r, ovfe_nxt;
  logic [PTR_W-1:0] vi_r, vi_nxt;

  // bookkeeping for the result step, used while busy_r is set
  logic             busy_r;
  logic             load_r, load_nxt;
  logic             rd_base_r, rd_base_nxt;
  logic             pdi_r, pdi_nxt;
  logic [LVL_W-1:0] sv_lvl_r, sv_lvl_nxt;
  logic [CLS_W-1:0] sv_cls_r, sv_cls_nxt;
  logic             sv_rem_r, sv_rem_nxt;

  logic             out_valid_r;
  out_word_t        out_r, out_nxt;

  // memory port
  logic             we;
  logic [PTR_W-1:0] waddr, raddr;
  entry_t           wdata;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t           rdata;

  // accept-time view of the state after any paragraph restart
  logic             in_fire;
  logic             ps;
  logic             eff_base;
  entry_t           eff_top;
  logic [PTR_W-1:0] eff_depth, eff_iso;
  logic [CNT_W-1:0] eff_ovfi, eff_ovfe;
  logic [PTR_W-1:0] eff_vi;
  logic [CLS_W-1:0] cls_m;
  logic [LVL_W:0]   nl_odd, nl_even, nl;
  logic             can_push;
  entry_t           base_ent, top_b;
  logic [1:0]       ov_sel;

  assign in_fire   = in_valid && in_ready;
  // take a new word once no word is in flight and the held result is leaving or gone
  assign in_ready  = !busy_r && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rdata     = entry_t'(rdata_raw);

  ber_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_SLOTS)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_comb begin
    ps        = in_data.para_start;
    eff_base  = ps ? para_lvl_r : base_r;
    base_ent  = '{iso: 1'b0, below: '0, ov: OV_NONE, lvl: {{(LVL_W-1){1'b0}}, eff_base}};
    eff_top   = ps ? base_ent : top_r;
    eff_depth = ps ? PTR_W'(1) : depth_r;
    eff_iso   = ps ? '0 : iso_dep_r;
    eff_ovfi  = ps ? '0 : ovfi_r;
    eff_ovfe  = ps ? '0 : ovfe_r;
    eff_vi    = ps ? '0 : vi_r;

    cls_m = in_data.char_class;
    if (in_data.char_class == C_FSI) begin
      cls_m = in_data.fsi_is_rtl ? C_RLI : C_LRI;
    end
    nl_odd  = ({1'b0, eff_top.lvl} + 8'd1) | 8'd1;
    nl_even = ({1'b0, eff_top.lvl} + 8'd2) & ~8'd1;
    nl = (cls_m == C_RLE || cls_m == C_RLO || cls_m == C_RLI) ? nl_odd : nl_even;
    can_push = (nl <= (LVL_W+1)'(MAX_LEVEL)) && eff_ovfe == '0 && eff_ovfi == '0
               && eff_depth < PTR_W'(STACK_SLOTS);

    // override of the current top applies to ordinary characters and isolates
    unique case (eff_top.ov)
      OV_LTR:  ov_sel = OV_LTR;
      OV_RTL:  ov_sel = OV_RTL;
      default: ov_sel = OV_NONE;
    endcase
  end

  always_comb begin
    top_nxt     = top_r;
    depth_nxt   = depth_r;
    iso_dep_nxt = iso_dep_r;
    ovfi_nxt    = ovfi_r;
    ovfe_nxt    = ovfe_r;
    vi_nxt      = vi_r;
    load_nxt    = 1'b0;
    rd_base_nxt = rd_base_r;
    pdi_nxt     = pdi_r;
    sv_lvl_nxt  = sv_lvl_r;
    sv_cls_nxt  = sv_cls_r;
    sv_rem_nxt  = sv_rem_r;
    we          = 1'b0;
    waddr       = eff_depth;
    wdata       = '{iso: 1'b0, below: eff_iso, ov: OV_NONE, lvl: nl[LVL_W-1:0]};
    raddr       = '0;
    out_nxt     = out_r;
    top_b       = top_r;

    if (in_fire) begin
      top_nxt     = eff_top;
      depth_nxt   = eff_depth;
      iso_dep_nxt = eff_iso;
      ovfi_nxt    = eff_ovfi;
      ovfe_nxt    = eff_ovfe;
      vi_nxt      = eff_vi;
      pdi_nxt     = 1'b0;
      sv_rem_nxt  = 1'b0;
      sv_lvl_nxt  = eff_top.lvl;
      sv_cls_nxt  = in_data.char_class;
      if (ov_sel == OV_LTR) begin
        sv_cls_nxt = C_L;
      end else if (ov_sel == OV_RTL) begin
        sv_cls_nxt = C_R;
      end

      priority if (cls_m == C_LRE || cls_m == C_LRO || cls_m == C_RLE || cls_m == C_RLO) begin
        sv_rem_nxt = 1'b1;
        if (can_push) begin
          we        = 1'b1;
          wdata.ov  = (cls_m == C_LRO) ? OV_LTR : (cls_m == C_RLO) ? OV_RTL : OV_NONE;
          top_nxt   = wdata;
          depth_nxt = eff_depth + PTR_W'(1);
        end else if (eff_ovfi == '0 && eff_ovfe != '1) begin
          ovfe_nxt = eff_ovfe + CNT_W'(1);
        end
      end else if (cls_m == C_LRI || cls_m == C_RLI) begin
        if (can_push) begin
          we          = 1'b1;
          wdata.iso   = 1'b1;
          top_nxt     = wdata;
          depth_nxt   = eff_depth + PTR_W'(1);
          iso_dep_nxt = eff_depth + PTR_W'(1);
          if (eff_vi != '1) begin
            vi_nxt = eff_vi + PTR_W'(1);
          end
        end else if (eff_ovfi != '1) begin
          ovfi_nxt = eff_ovfi + CNT_W'(1);
        end
      end else if (cls_m == C_PDI) begin
        // level and override come from the top after the pop, picked up while busy
        pdi_nxt    = 1'b1;
        sv_cls_nxt = in_data.char_class;
        if (eff_ovfi != '0) begin
          ovfi_nxt = eff_ovfi - CNT_W'(1);
        end else if (eff_vi != '0) begin
          ovfe_nxt    = '0;
          depth_nxt   = eff_iso - PTR_W'(1);
          raddr       = eff_iso - PTR_W'(2);
          rd_base_nxt = (eff_iso == PTR_W'(2));
          load_nxt    = 1'b1;
          vi_nxt      = eff_vi - PTR_W'(1);
        end
      end else if (cls_m == C_PDF) begin
        sv_rem_nxt = 1'b1;
        if (eff_ovfi != '0) begin
          ovfi_nxt = eff_ovfi;
        end else if (eff_ovfe != '0) begin
          ovfe_nxt = eff_ovfe - CNT_W'(1);
        end else if (!eff_top.iso && eff_depth >= PTR_W'(2)) begin
          depth_nxt   = eff_depth - PTR_W'(1);
          raddr       = eff_depth - PTR_W'(2);
          rd_base_nxt = (eff_depth == PTR_W'(2));
          load_nxt    = 1'b1;
        end
      end else if (cls_m == C_B) begin
        sv_lvl_nxt = {{(LVL_W-1){1'b0}}, para_lvl_r};
        sv_cls_nxt = in_data.char_class;
      end else if (cls_m == C_BN) begin
        sv_rem_nxt = 1'b1;
      end else begin
        sv_rem_nxt = 1'b0;
      end
    end

    // while busy: pick up popped top and build the result word
    if (busy_r) begin
      if (load_r) begin
        top_b = rd_base_r
              ? '{iso: 1'b0, below: '0, ov: OV_NONE, lvl: {{(LVL_W-1){1'b0}}, base_r}}
              : rdata;
        top_nxt     = top_b;
        iso_dep_nxt = top_b.iso ? depth_r : top_b.below;
      end
      out_nxt.removed   = sv_rem_r;
      out_nxt.level     = sv_lvl_r;
      out_nxt.out_class = sv_cls_r;
      if (pdi_r) begin
        out_nxt.level = top_b.lvl;
        if (top_b.ov == OV_LTR) begin
          out_nxt.out_class = C_L;
        end else if (top_b.ov == OV_RTL) begin
          out_nxt.out_class = C_R;
        end
      end
      if (sv_rem_r) begin
        out_nxt.level     = '0;
        out_nxt.out_class = C_BN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      para_lvl_r  <= 1'b0;
      base_r      <= 1'b0;
      top_r       <= '0;
      depth_r     <= PTR_W'(1);
      iso_dep_r   <= '0;
      ovfi_r      <= '0;
      ovfe_r      <= '0;
      vi_r        <= '0;
      busy_r      <= 1'b0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        para_lvl_r <= cfg_data;
      end
      if (in_fire && in_data.para_start) begin
        base_r <= para_lvl_r;
      end
      top_r     <= top_nxt;
      depth_r   <= depth_nxt;
      iso_dep_r <= iso_dep_nxt;
      ovfi_r    <= ovfi_nxt;
      ovfe_r    <= ovfe_nxt;
      vi_r      <= vi_nxt;
      busy_r    <= in_fire;
      load_r    <= load_nxt;
      if (busy_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    rd_base_r <= rd_base_nxt;
    pdi_r     <= pdi_nxt;
    sv_lvl_r  <= sv_lvl_nxt;
    sv_cls_r  <= sv_cls_nxt;
    sv_rem_r  <= sv_rem_nxt;
    out_r     <= out_nxt;
  end

endmodule
`default_nettype wire

### tb/sv/ber_checker.sv
`timescale 1ns / 1ps
module ber_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  ber_pkg::in_word_t  in_data,
  input  wire                out_valid,
  input  wire                out_ready,
  input  ber_pkg::out_word_t out_data,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire                cfg_data,
  output int                 fails,
  output int                 pending
);
  import ber_pkg::*;

  localparam int unsigned MAX_LVL = 125;
  localparam int unsigned CNT_TOP = 65535;

  logic [LVL_W-1:0] lvl_mem [STACK_SLOTS];
  logic [1:0]       ov_mem  [STACK_SLOTS];
  logic             iso_mem [STACK_SLOTS];
  int unsigned depth, ovf_iso, ovf_emb, live_iso;
  logic para_lvl;
  out_word_t level_q[$];

  task automatic report(input string what, input int got, input int want);
    $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic new_paragraph();
    lvl_mem[0] = LVL_W'(para_lvl);
    ov_mem[0]  = OV_NONE;
    iso_mem[0] = 1'b0;
    depth = 1;
    ovf_iso = 0;
    ovf_emb = 0;
    live_iso = 0;
  endtask

  function automatic logic [CLS_W-1:0] overridden(input logic [CLS_W-1:0] c);
    if (ov_mem[depth-1] == OV_LTR) return C_L;
    if (ov_mem[depth-1] == OV_RTL) return C_R;
    return c;
  endfunction

  function automatic int unsigned raised(input bit odd);
    int unsigned n;
    n = lvl_mem[depth-1];
    return odd ? ((n + 1) | 1) : ((n + 2) & ~32'd1);
  endfunction

  function automatic bit room(input int unsigned nl);
    return nl <= MAX_LVL && ovf_emb == 0 && ovf_iso == 0 && depth < STACK_SLOTS;
  endfunction

  task automatic push(input int unsigned nl, input logic [1:0] ov, input logic iso);
    lvl_mem[depth] = LVL_W'(nl);
    ov_mem[depth]  = ov;
    iso_mem[depth] = iso;
    depth++;
  endtask

  // rules x1-x9 for one character
  task automatic resolve(input in_word_t w, output out_word_t r);
    logic [CLS_W-1:0] c;
    int unsigned nl;
    bit gone;
    gone = 1'b0;
    r.level = '0;
    r.out_class = w.char_class;
    if (w.para_start) new_paragraph();
    c = w.char_class;
    if (c == C_FSI) c = w.fsi_is_rtl ? C_RLI : C_LRI;
    case (c)
      C_LRE, C_LRO, C_RLE, C_RLO: begin
        nl = raised(c == C_RLE || c == C_RLO);
        if (room(nl)) push(nl, c == C_LRO ? OV_LTR : c == C_RLO ? OV_RTL : OV_NONE, 1'b0);
        else if (ovf_iso == 0 && ovf_emb < CNT_TOP) ovf_emb++;
        gone = 1'b1;
      end
      C_LRI, C_RLI: begin
        nl = raised(c == C_RLI);
        r.level = lvl_mem[depth-1];
        r.out_class = overridden(w.char_class);
        if (room(nl)) begin
          push(nl, OV_NONE, 1'b1);
          if (live_iso < 127) live_iso++;
        end else if (ovf_iso < CNT_TOP) ovf_iso++;
      end
      C_PDI: begin
        if (ovf_iso > 0) ovf_iso--;
        else if (live_iso > 0) begin
          ovf_emb = 0;
          while (depth > 1 && !iso_mem[depth-1]) depth--;
          if (depth > 1) depth--;
          live_iso--;
        end
        r.level = lvl_mem[depth-1];
        r.out_class = overridden(w.char_class);
      end
      C_PDF: begin
        if (ovf_iso > 0) ;
        else if (ovf_emb > 0) ovf_emb--;
        else if (!iso_mem[depth-1] && depth >= 2) depth--;
        gone = 1'b1;
      end
      C_B: r.level = LVL_W'(para_lvl);
      C_BN: gone = 1'b1;
      default: begin
        r.level = lvl_mem[depth-1];
        r.out_class = overridden(w.char_class);
      end
    endcase
    if (gone) begin
      r.level = '0;
      r.out_class = C_BN;
    end
    r.removed = gone;
  endtask

  always @(posedge clk) begin
    out_word_t want, got;
    if (!rst_n) begin
      para_lvl = 1'b0;
      new_paragraph();
      level_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (level_q.size() == 0) begin
          $display("tb: unexpected word at %0t", $realtime);
          fails++;
        end else begin
          want = level_q.pop_front();
          if (got.level !== want.level) report("level", got.level, want.level);
          if (got.out_class !== want.out_class)
            report("out_class", got.out_class, want.out_class);
          if (got.removed !== want.removed) report("removed", got.removed, want.removed);
        end
      end
      if (in_valid && in_ready) begin
        resolve(in_data, want);
        level_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) para_lvl = cfg_data;
    end
    pending = level_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
  end
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ber_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  int fails, pending;
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit burst_off = 1'b0;  // sender offers back to back while set
  int sent = 0;

  always #5 clk = ~clk;

  bidi_explicit_level_resolver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ber_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  // receiver: random stall pattern, runs of always-ready, and one long hold
  initial begin
    int run, mode;
    forever begin
      if (hold_req) begin
        repeat (300) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      run = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (run) begin
        // modes 0 and 1 never stall, modes 2 and 3 stall with rising odds
        out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode - 1);
        @(posedge clk);
      end
    end
  end

  // offer one word and hold it until taken; a random gap may follow
  task automatic send(input logic [CLS_W-1:0] c, input logic fsi, input logic ps);
    int gap;
    in_valid <= 1'b1;
    in_data <= in_word_t'{char_class: c, fsi_is_rtl: fsi, para_start: ps};
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = burst_off ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(1, 8) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // idle point: every expected word back, then a settle wait
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_level(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // weighted class pick: content, openers, closers, BN and B, and the odd rare code
  function automatic logic [CLS_W-1:0] pick_class(input int push_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CLS_W'($urandom_range(0, 13));
    if (r < 30 + push_bias) return CLS_W'($urandom_range(14, 21)) == C_PDF ? C_LRE
                                   : CLS_W'($urandom_range(14, 21));
    if (r < 90) return ($urandom_range(0, 1) ? C_PDF : C_PDI);
    if (r < 95) return ($urandom_range(0, 1) ? C_BN : C_B);
    return CLS_W'($urandom_range(23, 31));
  endfunction

  task automatic random_words(input int n, input int push_bias);
    repeat (n)
      send(pick_class(push_bias), 1'($urandom), $urandom_range(0, 49) == 0);
  endtask

  // nest deep enough to hit the top level and overflow, then unwind
  task automatic deep_nest();
    for (int k = 0; k < 140; k++) begin
      case ($urandom_range(0, 5))
        0: send(C_LRE, 1'b0, 1'b0);
        1: send(C_RLE, 1'b0, 1'b0);
        2: send(C_LRO, 1'b0, 1'b0);
        3: send(C_RLO, 1'b0, 1'b0);
        4: send(C_FSI, 1'($urandom), 1'b0);
        default: send(CLS_W'($urandom_range(0, 13)), 1'b0, 1'b0);
      endcase
    end
    repeat (150) send(($urandom_range(0, 2) == 0) ? C_PDI : C_PDF, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every class, fsi both ways, unknown code, paragraph start
    set_level(1'b0);
    for (int c = 0; c <= 22; c++) send(CLS_W'(c), 1'b0, c == 0);
    send(C_FSI, 1'b1, 1'b0);
    send(CLS_W'(31), 1'b1, 1'b0);
    send(C_RLO, 1'b1, 1'b1);
    send(CLS_W'(31), 1'b1, 1'b0);
    drain();

    // rtl paragraph, mixed traffic
    set_level(1'b1);
    send(C_L, 1'b0, 1'b1);
    random_words(140, 25);
    drain();

    // ltr level written mid paragraph, then deep nesting
    set_level(1'b0);
    deep_nest();
    drain();

    // pressure: long receiver hold while sender keeps offering
    set_level(1'b1);
    hold_req = 1'b1;
    burst_off = 1'b1;
    random_words(60, 30);
    burst_off = 1'b0;
    drain();

    set_level(1'b0);
    send(C_L, 1'b0, 1'b1);
    random_words(40, 45);
    drain();

    // sender waits out every result between short bursts
    set_level(1'b1);
    repeat (4) begin
      random_words(10, 25);
      drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
